// ===== rtl/core/wht_pkg.sv =====
// Package for the word hash tokenizer: field widths, hash constants,
// register index codes, the result record type and the byte classifier.
// No dependencies.
`default_nettype none

package wht_pkg;

    localparam int BYTE_W   = 8;
    localparam int HASH_W   = 64;
    localparam int WORDS_W  = 9;
    localparam int LENGTH_W = 13;
    localparam int INDEX_W  = 1;
    localparam int DATA_W   = 13;

    localparam logic [HASH_W-1:0]   HASH_SEED = 64'd5381;
    localparam logic [LENGTH_W-1:0] BYTES_SAT = 13'd8191;
    localparam logic [WORDS_W-1:0]  WORDS_SAT = 9'd511;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [INDEX_W-1:0] {
        REG_MAX_WORDS  = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [HASH_W-1:0]  word_hash;
        logic [WORDS_W-1:0] word_total;
        logic               closing;
    } t_result;

    function automatic logic is_mark(input logic [BYTE_W-1:0] b);
        logic p;
        p = (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
            (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
        return p;
    endfunction

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b | 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/word_hash_tokenizer.sv =====
// Word hash tokenizer top level: byte classification, djb2 hash update and
// a four-entry result queue. Depends on wht_pkg.
//
//   channel  direction  handshake                  payload
//   in       request    i_in_valid / o_in_ready    i_text_byte, i_record_end
//   out      result     o_out_valid / i_out_ready  o_word_hash, o_word_total, o_closing
//   cfg      write      i_cfg_wr_en                i_cfg_index, i_cfg_wr_data
//
// One byte is taken per cycle; its results land in the result queue at the next edge.
// A byte gives up to two results (a word hash and the closing result at record end).
// The queue drains one result per cycle; o_in_ready drops while fewer than two slots
// are free, so input stalls only when results come faster than one per cycle
// (back-to-back record ends) or the output side holds off.
// Reset (synchronous, active low) empties the queue and restores registers and state.
`default_nettype none

module word_hash_tokenizer #(
    parameter int WORD_LIMIT   = 256,
    parameter int LENGTH_LIMIT = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [wht_pkg::INDEX_W-1:0]      i_cfg_index,
    input  wire logic [wht_pkg::DATA_W-1:0]       i_cfg_wr_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [wht_pkg::BYTE_W-1:0]       i_text_byte,
    input  wire logic                             i_record_end,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [wht_pkg::HASH_W-1:0]            o_word_hash,
    output logic [wht_pkg::WORDS_W-1:0]           o_word_total,
    output logic                                  o_closing
);
    import wht_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [WORDS_W-1:0] WORD_CAP =
        (WORD_LIMIT < 511) ? WORDS_W'(WORD_LIMIT) : WORDS_SAT;
    localparam logic [LENGTH_W-1:0] LENGTH_CAP =
        (LENGTH_LIMIT < 8191) ? LENGTH_W'(LENGTH_LIMIT) : BYTES_SAT;

    logic [WORDS_W-1:0]  r_max_words;
    logic [LENGTH_W-1:0] r_max_length;

    logic [HASH_W-1:0]   r_hash,       n_hash;
    logic                r_inside,     n_inside;
    logic [WORDS_W-1:0]  r_words_done, n_words_done;
    logic [LENGTH_W-1:0] r_bytes_seen, n_bytes_seen;

    t_result             r_queue [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]    r_count,  n_count;

    logic                accept, pop;
    logic [WORDS_W-1:0]  word_cap;
    logic [LENGTH_W-1:0] length_cap;
    logic                consider, is_nul, is_sep, is_char;
    logic [BYTE_W-1:0]   lc_byte;
    logic [HASH_W-1:0]   char_ext, hash_upd, hash_after;
    logic                inside_after, emit_word;
    logic [WORDS_W-1:0]  words_after;
    t_result             word_res, close_res, res0, res1;
    logic                push0, push1;
    logic [CNT_W-1:0]    push_cnt;

    assign accept     = i_in_valid && o_in_ready;
    assign pop        = o_out_valid && i_out_ready;
    assign o_in_ready = (r_count <= CNT_W'(DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_word_hash  = r_queue[r_rd_ptr].word_hash;
    assign o_word_total = r_queue[r_rd_ptr].word_total;
    assign o_closing    = r_queue[r_rd_ptr].closing;

    assign word_cap   = (r_max_words < WORD_CAP) ? r_max_words : WORD_CAP;
    assign length_cap = (r_max_length < LENGTH_CAP) ? r_max_length : LENGTH_CAP;

    always_comb begin
        consider = (r_bytes_seen < length_cap);
        is_nul   = (i_text_byte == CHAR_NUL);
        is_sep   = consider && (is_nul || i_text_byte == CHAR_SPACE);
        is_char  = consider && !is_nul && (i_text_byte != CHAR_SPACE) &&
                   !is_mark(i_text_byte);
        lc_byte  = fold_case(i_text_byte);
        char_ext = {{(HASH_W - BYTE_W){lc_byte[BYTE_W-1]}}, lc_byte};
        hash_upd = (r_hash << 5) + r_hash + char_ext;

        hash_after   = is_char ? hash_upd : r_hash;
        inside_after = is_char ? 1'b1 : r_inside;

        // a word ends on a separator or at record end
        emit_word   = ((is_sep && r_inside) || (!is_sep && i_record_end && inside_after))
                      && (r_words_done < word_cap);
        words_after = r_words_done + WORDS_W'(emit_word);

        word_res.word_hash   = is_sep ? r_hash : hash_after;
        word_res.word_total  = '0;
        word_res.closing     = 1'b0;
        close_res.word_hash  = '0;
        close_res.word_total = words_after;
        close_res.closing    = 1'b1;

        res0  = emit_word ? word_res : close_res;
        res1  = close_res;
        push0 = accept && (emit_word || i_record_end);
        push1 = accept && emit_word && i_record_end;
        push_cnt = CNT_W'(push0) + CNT_W'(push1);
        n_count  = r_count + push_cnt - CNT_W'(pop);

        n_hash       = r_hash;
        n_inside     = r_inside;
        n_words_done = r_words_done;
        n_bytes_seen = r_bytes_seen;
        if (accept) begin
            if (i_record_end) begin
                n_hash       = HASH_SEED;
                n_inside     = 1'b0;
                n_words_done = '0;
                n_bytes_seen = '0;
            end else begin
                n_hash       = is_sep ? HASH_SEED : hash_after;
                n_inside     = is_sep ? 1'b0 : inside_after;
                n_words_done = words_after;
                if (consider) begin
                    n_bytes_seen = is_nul ? BYTES_SAT : r_bytes_seen + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_words  <= 9'd256;
            r_max_length <= 13'd4096;
        end else if (i_cfg_wr_en) begin
            case (t_reg_index'(i_cfg_index))
                REG_MAX_WORDS:  r_max_words  <= i_cfg_wr_data[WORDS_W-1:0];
                REG_MAX_LENGTH: r_max_length <= i_cfg_wr_data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash       <= HASH_SEED;
            r_inside     <= 1'b0;
            r_words_done <= '0;
            r_bytes_seen <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            r_hash       <= n_hash;
            r_inside     <= n_inside;
            r_words_done <= n_words_done;
            r_bytes_seen <= n_bytes_seen;
            r_count      <= n_count;
            r_wr_ptr     <= r_wr_ptr + PTR_W'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push1) begin
            r_queue[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_closing_zero_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_closing |-> o_word_hash == '0)
        else $error("closing result carries a hash");

    a_word_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_closing |-> o_word_total == '0)
        else $error("word result carries a count");

    a_record_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_record_end |=>
            r_bytes_seen == '0 && !r_inside && r_words_done == '0 && r_hash == HASH_SEED)
        else $error("record state not cleared");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 r_count == $past(r_count) + $past(push_cnt) - CNT_W'($past(pop)))
        else $error("queue count mismatch");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for word_hash_tokenizer: drives text bytes with random gaps and
// back-pressure and checks every word hash and closing count against a model.
// Depends on wht_pkg and the word_hash_tokenizer RTL.
`default_nettype none

module tb_top;
    import wht_pkg::*;

    localparam int WORD_LIMIT    = 256;
    localparam int LENGTH_LIMIT  = 4096;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 130;

    class word_hash_board;
        t_result             hashes_due[$];
        int                  errors;
        logic [WORDS_W-1:0]  words_reg;
        logic [LENGTH_W-1:0] length_reg;
        logic [HASH_W-1:0]   acc_hash;
        bit                  mid_word;
        logic [WORDS_W-1:0]  words_out;
        logic [LENGTH_W-1:0] bytes_used;

        function new();
            errors     = 0;
            words_reg  = 9'd256;
            length_reg = 13'd4096;
            clear_record();
        endfunction

        function void clear_record();
            acc_hash   = HASH_SEED;
            mid_word   = 1'b0;
            words_out  = '0;
            bytes_used = '0;
        endfunction

        function void set_register(t_reg_index idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MAX_WORDS: begin
                    words_reg = value[WORDS_W-1:0];
                end
                REG_MAX_LENGTH: begin
                    length_reg = value[LENGTH_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int word_cap();
            int c;
            c = words_reg;
            if (c > WORD_LIMIT) c = WORD_LIMIT;
            return c;
        endfunction

        function int length_cap();
            int c;
            c = length_reg;
            if (c > LENGTH_LIMIT) c = LENGTH_LIMIT;
            return c;
        endfunction

        function void close_word();
            if (mid_word) begin
                if (words_out < word_cap()) begin
                    hashes_due.push_back(t_result'{word_hash: acc_hash, word_total: '0,
                                                   closing: 1'b0});
                    words_out++;
                end
                acc_hash = HASH_SEED;
                mid_word = 1'b0;
            end
        endfunction

        function void note_request(logic [BYTE_W-1:0] b, logic last);
            logic [BYTE_W-1:0] ch;
            if (bytes_used < length_cap()) begin
                bytes_used++;
                if (b == CHAR_NUL) begin
                    close_word();
                    bytes_used = BYTES_SAT;
                end else if (b == CHAR_SPACE) begin
                    close_word();
                end else if (!(b inside {[8'h21:8'h2F], [8'h3A:8'h40],
                                         [8'h5B:8'h60], [8'h7B:8'h7E]})) begin
                    ch = (b inside {[8'h41:8'h5A]}) ? b + 8'h20 : b;
                    acc_hash = (acc_hash << 5) + acc_hash +
                               {{(HASH_W-BYTE_W){ch[BYTE_W-1]}}, ch};
                    mid_word = 1'b1;
                end
            end
            if (last) begin
                close_word();
                hashes_due.push_back(t_result'{word_hash: '0, word_total: words_out,
                                               closing: 1'b1});
                clear_record();
            end
        endfunction

        function void check_result(logic [HASH_W-1:0] h, logic [WORDS_W-1:0] total,
                                   logic close_flag);
            t_result want;
            if (hashes_due.size() == 0) begin
                $display("%0t: unexpected result hash %h total %0d closing %0b",
                         $time, h, total, close_flag);
                errors++;
                return;
            end
            want = hashes_due.pop_front();
            if (h !== want.word_hash) begin
                $display("%0t: word_hash expected %h got %h", $time, want.word_hash, h);
                errors++;
            end
            if (total !== want.word_total) begin
                $display("%0t: word_total expected %0d got %0d", $time,
                         want.word_total, total);
                errors++;
            end
            if (close_flag !== want.closing) begin
                $display("%0t: closing expected %0b got %0b", $time, want.closing,
                         close_flag);
                errors++;
            end
        endfunction

        function int pending();
            return hashes_due.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [INDEX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]   cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   text_byte;
    logic                record_end;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [HASH_W-1:0]   word_hash;
    logic [WORDS_W-1:0]  word_total;
    logic                closing;

    word_hash_board board;
    bit  calm = 1'b0;
    bit  in_taken = 1'b0;
    int  idle_cycles = 0;
    int  ready_left = 0;
    int  stall;

    word_hash_tokenizer #(
        .WORD_LIMIT  (WORD_LIMIT),
        .LENGTH_LIMIT(LENGTH_LIMIT)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_text_byte  (text_byte),
        .i_record_end (record_end),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_word_hash  (word_hash),
        .o_word_total (word_total),
        .o_closing    (closing)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_char(bit with_nul);
        int    r;
        string marks;
        marks = "!\"#$%&'()*+,-./:;<=>?@[\\]^_`{|}~";
        r = $urandom_range(0, 99);
        if (r < 45) return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 58) return 8'h41 + 8'($urandom_range(0, 25));
        if (r < 78) return CHAR_SPACE;
        if (r < 86) return marks[$urandom_range(0, marks.len() - 1)];
        if (r == 86) return with_nul ? CHAR_NUL : CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Handshakes are judged at the falling edge; the rising edge then takes them.
    always @(negedge clk) begin
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken) board.note_request(text_byte, record_end);
        if (rst_n && out_valid && out_ready) begin
            board.check_result(word_hash, word_total, closing);
        end
        if (in_taken || (rst_n && out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("word_hash_tokenizer: mismatch");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (out_ready) begin
            stall = pick_gap();
            if (stall != 0) begin
                out_ready  <= 1'b0;
                ready_left <= stall - 1;
            end else begin
                ready_left <= $urandom_range(0, 15);
            end
        end else begin
            out_ready  <= 1'b1;
            ready_left <= $urandom_range(0, 15);
        end
    end

    task automatic send_request(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        record_end <= last;
        do @(posedge clk); while (!in_taken);
    endtask

    task automatic send_text(input string s, input bit close_it);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], close_it && (i == s.len() - 1));
        end
    endtask

    task automatic send_record(input int n_bytes, input bit close_it, input bit with_nul);
        for (int i = 0; i < n_bytes; i++) begin
            send_request(pick_char(with_nul), close_it && (i == n_bytes - 1));
        end
    endtask

    // Hold off until every result is out and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_limits(input int words, input int length);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_MAX_WORDS;
        cfg_wr_data <= DATA_W'(words);
        board.set_register(REG_MAX_WORDS, DATA_W'(words));
        @(posedge clk);
        cfg_index   <= REG_MAX_LENGTH;
        cfg_wr_data <= DATA_W'(length);
        board.set_register(REG_MAX_LENGTH, DATA_W'(length));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int pick_words();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 256;
            2: return $urandom_range(1, 4);
            3: return $urandom_range(1, 256);
            4: return 511;
            default: return 0;
        endcase
    endfunction

    function automatic int pick_length();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 4096;
            2: return $urandom_range(1, 12);
            3: return $urandom_range(13, 60);
            4: return 8191;
            default: return $urandom_range(0, 1) ? 0 : $urandom_range(61, 4095);
        endcase
    endfunction

    initial begin
        int sent;
        int n;
        int r;
        board = new();
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_MAX_WORDS;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        text_byte   <= '0;
        record_end  <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // punctuation edges, capitals, digits, high and control bytes
        send_text("A!/0:@[`{~Z9  z", 1);
        send_request(8'h80, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h09, 1'b0);
        send_request(CHAR_SPACE, 1'b1);
        // zero byte ends the text, the rest is skipped
        send_request(8'h61, 1'b0);
        send_request(CHAR_NUL, 1'b0);
        send_request(8'h71, 1'b1);
        send_request(CHAR_SPACE, 1'b1);

        drain();
        program_limits(1, 1);
        send_text("ab c", 1);
        drain();
        program_limits(0, 0);
        send_text("a", 1);
        drain();
        program_limits(2, 2);
        send_text("abc d", 1);
        // change limits in the middle of a record
        drain();
        program_limits(511, 8191);
        send_text("ab", 0);
        drain();
        program_limits(256, 4096);
        send_text(" c", 1);

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            calm = ($urandom_range(0, 3) == 0);
            program_limits(pick_words(), pick_length());
            sent = 0;
            while (sent < PHASE_BYTES) begin
                r = $urandom_range(0, 9);
                n = (r == 0) ? 1 : (r < 8) ? $urandom_range(2, 24) : $urandom_range(25, 80);
                send_record(n, (sent + n < PHASE_BYTES) || ($urandom_range(0, 3) != 0), 1'b1);
                sent += n;
            end
        end

        // one long record runs into both the word and the length limit
        drain();
        calm = 1'b0;
        program_limits(16, 300);
        send_record(400, 1'b1, 1'b0);

        drain();
        if (board.errors == 0) begin
            $display("word_hash_tokenizer: match");
        end else begin
            $display("word_hash_tokenizer: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== word_hash_tokenizer.f =====
rtl/core/wht_pkg.sv
rtl/core/word_hash_tokenizer.sv
dv/tb_top.sv
